FILE: rtl/min_coin_count_dp_macros.svh
// Assertion macros shared by the RTL of the coin change block.
`ifndef MIN_COIN_COUNT_DP_MACROS_SVH
`define MIN_COIN_COUNT_DP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("min_coin_count_dp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("min_coin_count_dp: next-cycle check failed");

`endif

FILE: rtl/mccdp_pkg.sv
package mccdp_pkg;

    localparam int AMT_W          = 12;
    localparam int ENTRY_W        = 13;
    localparam int COIN_SLOTS     = 8;
    localparam int SLOT_IDX_W     = 3;
    localparam int AMT_MAX        = (2 ** AMT_W) - 1;
    localparam int MAX_AMOUNT_DEF = 4095;
    localparam int NUM_COINS_DEF  = 8;

    typedef logic [AMT_W-1:0]   t_amount;
    typedef logic [ENTRY_W-1:0] t_entry;

endpackage

FILE: rtl/min_coin_count_dp.sv
// Channel   Direction  Signals                                     Carries
// request   in         i_in_valid, o_in_ready, i_target_amount     target amount
// result    out        o_out_valid, i_out_ready, o_reachable,      fewest coin count
//                      o_fewest_coins
// config    in         i_cfg_wr_en, i_cfg_index, i_cfg_wdata       coin denominations
//
// A request for amount A works through the sums 1 to A, checking each coin slot
// per sum before its result is registered; amount zero and amounts above the
// table skip the search. The single table read port sets the pace: one coin is
// checked per cycle, and each sum ends with a step that writes its table entry.
// Reset is synchronous and active low; it clears the coin registers and the control.
// A waiting result does not block the next request, but a finished request holds
// its result until the output register is free.

`include "min_coin_count_dp_macros.svh"

module min_coin_count_dp #(
    parameter int MAX_AMOUNT = mccdp_pkg::MAX_AMOUNT_DEF,
    parameter int NUM_COINS  = mccdp_pkg::NUM_COINS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mccdp_pkg::AMT_W-1:0]          i_target_amount,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_reachable,
    output logic [mccdp_pkg::AMT_W-1:0]          o_fewest_coins,
    input  logic                                 i_cfg_wr_en,
    input  logic [mccdp_pkg::SLOT_IDX_W-1:0]     i_cfg_index,
    input  logic [mccdp_pkg::AMT_W-1:0]          i_cfg_wdata
);

    localparam int TBL_DEPTH = ((MAX_AMOUNT < mccdp_pkg::AMT_MAX) ?
                                MAX_AMOUNT : mccdp_pkg::AMT_MAX) + 1;
    localparam int AW = $clog2(TBL_DEPTH);
    localparam int KW = $clog2(NUM_COINS + 1);
    localparam logic [mccdp_pkg::AMT_W-1:0] AMT_LIMIT = mccdp_pkg::AMT_W'(TBL_DEPTH - 1);
    localparam logic [KW-1:0] K_LAST = KW'(NUM_COINS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]              r_state, n_state;
    mccdp_pkg::t_amount      r_amount, n_amount;
    mccdp_pkg::t_amount      r_s, n_s;
    logic [KW-1:0]           r_k, n_k;
    mccdp_pkg::t_entry       r_entry, n_entry;
    logic                    r_pend, n_pend;
    mccdp_pkg::t_entry       r_rd_data;
    logic                    r_res_reach, n_res_reach;
    mccdp_pkg::t_amount      r_res_cnt, n_res_cnt;
    logic                    r_out_vld, n_out_vld;
    logic                    r_reach, n_reach;
    mccdp_pkg::t_amount      r_cnt, n_cnt;
    mccdp_pkg::t_amount      r_coin [mccdp_pkg::COIN_SLOTS];

    mccdp_pkg::t_entry       r_tbl [TBL_DEPTH];

    mccdp_pkg::t_amount      cur_coin;
    mccdp_pkg::t_amount      diff;
    logic                    usable;
    logic [AW-1:0]           rd_addr;
    mccdp_pkg::t_entry       cand;
    mccdp_pkg::t_entry       best;
    mccdp_pkg::t_entry       inf;
    logic                    tbl_we;
    logic [AW-1:0]           tbl_waddr;
    mccdp_pkg::t_entry       tbl_wdata;
    logic                    accept;
    logic                    load_out;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign load_out = (r_state == S_DONE) && (!r_out_vld || i_out_ready);

    always_comb begin
        cur_coin = '0;
        for (int j = 0; j < NUM_COINS; j++) begin
            if (r_k == KW'(j)) begin
                cur_coin = r_coin[j];
            end
        end
    end

    assign usable  = (r_k != K_LAST) && (cur_coin != '0) && (cur_coin <= r_s);
    assign diff    = r_s - cur_coin;
    assign rd_addr = diff[AW-1:0];
    assign cand    = r_rd_data + mccdp_pkg::ENTRY_W'(1);
    assign best    = (r_pend && (cand < r_entry)) ? cand : r_entry;
    assign inf     = mccdp_pkg::ENTRY_W'(r_amount) + mccdp_pkg::ENTRY_W'(1);

    always_comb begin
        n_state     = r_state;
        n_amount    = r_amount;
        n_s         = r_s;
        n_k         = r_k;
        n_entry     = r_entry;
        n_pend      = r_pend;
        n_res_reach = r_res_reach;
        n_res_cnt   = r_res_cnt;
        tbl_we      = 1'b0;
        tbl_waddr   = r_s[AW-1:0];
        tbl_wdata   = best;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_amount = i_target_amount;
                    if (i_target_amount == '0) begin
                        n_res_reach = 1'b1;
                        n_res_cnt   = '0;
                        n_state     = S_DONE;
                    end else if (i_target_amount > AMT_LIMIT) begin
                        n_res_reach = 1'b0;
                        n_res_cnt   = '0;
                        n_state     = S_DONE;
                    end else begin
                        tbl_we    = 1'b1;
                        tbl_waddr = '0;
                        tbl_wdata = '0;
                        n_s       = mccdp_pkg::AMT_W'(1);
                        n_k       = '0;
                        n_pend    = 1'b0;
                        n_entry   = mccdp_pkg::ENTRY_W'(i_target_amount)
                                    + mccdp_pkg::ENTRY_W'(1);
                        n_state   = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_entry = best;
                n_pend  = usable;
                if (r_k == K_LAST) begin
                    tbl_we  = 1'b1;
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_entry = inf;
                    if (r_s == r_amount) begin
                        n_res_reach = (best <= mccdp_pkg::ENTRY_W'(r_amount));
                        n_res_cnt   = (best <= mccdp_pkg::ENTRY_W'(r_amount)) ?
                                      best[mccdp_pkg::AMT_W-1:0] : '0;
                        n_state     = S_DONE;
                    end else begin
                        n_s = r_s + mccdp_pkg::AMT_W'(1);
                    end
                end else begin
                    n_k = r_k + KW'(1);
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld && !i_out_ready;
        n_reach   = r_reach;
        n_cnt     = r_cnt;
        if (load_out) begin
            n_out_vld = 1'b1;
            n_reach   = r_res_reach;
            n_cnt     = r_res_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
            r_k       <= '0;
            for (int j = 0; j < mccdp_pkg::COIN_SLOTS; j++) begin
                r_coin[j] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
            r_k       <= n_k;
            if (i_cfg_wr_en) begin
                r_coin[i_cfg_index] <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_amount    <= n_amount;
        r_s         <= n_s;
        r_entry     <= n_entry;
        r_res_reach <= n_res_reach;
        r_res_cnt   <= n_res_cnt;
        r_reach     <= n_reach;
        r_cnt       <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        r_rd_data <= r_tbl[rd_addr];
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_reachable    = r_reach;
    assign o_fewest_coins = r_cnt;

    `MCC_ASSERT_NEXT(a_busy_after_req, i_in_valid && o_in_ready, !o_in_ready)
    `MCC_ASSERT_SAME(a_unreach_zero, o_out_valid && !o_reachable, o_fewest_coins == '0)
    `MCC_ASSERT_SAME(a_run_bounds, r_state == S_RUN,
                     (r_s != '0) && (r_s <= r_amount) && (r_k <= K_LAST))

endmodule

FILE: tb/sv/min_coin_count_dp_checker.sv
`timescale 1ns / 1ps

module min_coin_count_dp_checker
    import mccdp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [AMT_W-1:0]      i_target_amount,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_reachable,
    input  logic [AMT_W-1:0]      i_fewest_coins,
    input  logic                  i_cfg_wr_en,
    input  logic [SLOT_IDX_W-1:0] i_cfg_index,
    input  logic [AMT_W-1:0]      i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic    reachable;
        t_amount fewest_coins;
    } t_coin_answer;

    t_amount      coin_store [COIN_SLOTS];
    int unsigned  best_count [MAX_AMOUNT_DEF+1];
    t_coin_answer answer_queue [$];
    int           mismatches = 0;

    // Fills the count table for every sum up to the amount, one coin slot at a time.
    function automatic t_coin_answer solve_fewest_coins(input t_amount amount);
        t_coin_answer answer;
        int unsigned  unreached;
        int unsigned  entry;
        int unsigned  cand;
        answer = '0;
        if (amount == '0) begin
            answer.reachable = 1'b1;
            return answer;
        end
        if (int'(amount) > MAX_AMOUNT_DEF) begin
            return answer;
        end
        unreached = int'(amount) + 1;
        best_count[0] = 0;
        for (int s = 1; s <= int'(amount); s++) begin
            entry = unreached;
            for (int k = 0; k < NUM_COINS_DEF; k++) begin
                if (coin_store[k] != '0 && int'(coin_store[k]) <= s) begin
                    cand = best_count[s - int'(coin_store[k])] + 1;
                    if (cand < entry) begin
                        entry = cand;
                    end
                end
            end
            best_count[s] = entry;
        end
        if (best_count[amount] <= int'(amount)) begin
            answer.reachable    = 1'b1;
            answer.fewest_coins = t_amount'(best_count[amount]);
        end
        return answer;
    endfunction

    task automatic report_mismatch(input string text);
        $display("%0t: mismatch: %s", $time, text);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_coin_answer got;
        t_coin_answer want;
        if (!i_rst_n) begin
            foreach (coin_store[k]) begin
                coin_store[k] = '0;
            end
            answer_queue.delete();
        end else begin
            if (i_cfg_wr_en) begin
                coin_store[i_cfg_index] = i_cfg_wdata;
            end
            if (i_out_valid && i_out_ready) begin
                got.reachable    = i_reachable;
                got.fewest_coins = i_fewest_coins;
                if (answer_queue.size() == 0) begin
                    report_mismatch($sformatf("result with no open request: reachable %0d count %0d",
                                              got.reachable, got.fewest_coins));
                end else begin
                    want = answer_queue.pop_front();
                    if (got.reachable !== want.reachable) begin
                        report_mismatch($sformatf("reachable got %0d, want %0d",
                                                  got.reachable, want.reachable));
                    end
                    if (got.fewest_coins !== want.fewest_coins) begin
                        report_mismatch($sformatf("fewest_coins got %0d, want %0d",
                                                  got.fewest_coins, want.fewest_coins));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                answer_queue.push_back(solve_fewest_coins(i_target_amount));
            end
        end
        o_pending    <= answer_queue.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/tb_min_coin_count_dp.sv
`timescale 1ns / 1ps

module tb_min_coin_count_dp;
    import mccdp_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 16;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  req_valid     = 1'b0;
    logic                  req_ready;
    t_amount               req_amount    = '0;
    logic                  res_valid;
    logic                  res_ready     = 1'b0;
    logic                  res_reachable;
    t_amount               res_fewest;
    logic                  cfg_wr_en     = 1'b0;
    logic [SLOT_IDX_W-1:0] cfg_index     = '0;
    t_amount               cfg_wdata     = '0;

    int      fail_count;
    int      pending;
    int      idle_cycles = 0;
    int      send_calm   = 0;
    int      take_calm   = 0;
    t_amount coin_plan [COIN_SLOTS];

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    min_coin_count_dp i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (req_valid),
        .o_in_ready      (req_ready),
        .i_target_amount (req_amount),
        .o_out_valid     (res_valid),
        .i_out_ready     (res_ready),
        .o_reachable     (res_reachable),
        .o_fewest_coins  (res_fewest),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    min_coin_count_dp_checker i_coin_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (req_valid),
        .i_in_ready      (req_ready),
        .i_target_amount (req_amount),
        .i_out_valid     (res_valid),
        .i_out_ready     (res_ready),
        .i_reachable     (res_reachable),
        .i_fewest_coins  (res_fewest),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Waits are drawn per request or per result, with occasional runs of back-to-back traffic.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left = calm_left - 1;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(3, 10);
        end
        return $urandom_range(0, 11);
    endfunction

    // Most amounts stay small, since the block checks every coin slot for each unit of amount.
    function automatic int draw_amount();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return $urandom_range(0, 4095);
        end
        if (pick < 10) begin
            return 0;
        end
        return $urandom_range(1, 150);
    endfunction

    function automatic t_amount draw_coin();
        case ($urandom_range(0, 3))
            0: begin
                return '0;
            end
            1: begin
                return t_amount'($urandom_range(1, 15));
            end
            2: begin
                return t_amount'($urandom_range(1, 60));
            end
            default: begin
                return t_amount'($urandom_range(1, 4095));
            end
        endcase
    endfunction

    task automatic send_request(input int amount);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_amount <= t_amount'(amount);
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic load_coins();
        for (int k = 0; k < COIN_SLOTS; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= SLOT_IDX_W'(k);
            cfg_wdata <= coin_plan[k];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int gap;
        wait (rst_n);
        forever begin
            gap = draw_wait(take_calm);
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    always @(posedge clk) begin
        if ((req_valid && req_ready) || (res_valid && res_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_min_coin_count_dp NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // With the coin registers at reset, only amount zero is reachable.
        send_request(0);
        send_request(1);
        send_request(5);
        drain();

        coin_plan = '{1, 0, 0, 0, 0, 0, 0, 0};
        load_coins();
        send_request(4095);
        send_request(2);
        drain();

        coin_plan = '{default: 12'hFFF};
        load_coins();
        send_request(4095);
        send_request(4094);
        drain();

        // A greedy choice fails here: six is two threes, not four plus two ones.
        coin_plan = '{0, 1, 0, 3, 0, 4, 0, 0};
        load_coins();
        send_request(6);
        send_request(7);
        send_request(10);
        send_request(0);
        drain();

        coin_plan = '{2, 0, 0, 0, 0, 0, 0, 7};
        load_coins();
        send_request(1);
        send_request(3);
        send_request(9);
        send_request(14);
        send_request(13);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            foreach (coin_plan[k]) begin
                coin_plan[k] = draw_coin();
            end
            load_coins();
            repeat (PHASE_REQUESTS) send_request(draw_amount());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_min_coin_count_dp OK");
        end else begin
            $display("tb_min_coin_count_dp NOT OK");
        end
        $finish;
    end

endmodule

FILE: min_coin_count_dp.f
+incdir+rtl
rtl/mccdp_pkg.sv
rtl/min_coin_count_dp.sv
tb/sv/min_coin_count_dp_checker.sv
tb/sv/tb_min_coin_count_dp.sv
